@@ hdl/mact_pkg.sv @@
package mact_pkg;

  localparam logic [8:0]  SHORT_RESET = 9'd5;
  localparam logic [8:0]  LONG_RESET  = 9'd20;
  localparam logic [15:0] QTY_RESET   = 16'd100;
  localparam logic [31:0] MONEY_RESET = 32'd100000;

  localparam logic [1:0] REG_SHORT = 2'd0;
  localparam logic [1:0] REG_LONG  = 2'd1;
  localparam logic [1:0] REG_QTY   = 2'd2;
  localparam logic [1:0] REG_MONEY = 2'd3;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_BUY  = 2'd1;
  localparam logic [1:0] ACT_SELL = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [23:0] trade_quantity;
    logic [31:0] short_average;
    logic [31:0] long_average;
    logic        enough_data;
    logic        budget_blocked;
  } result_t;

endpackage

@@ hdl/moving_average_crossover_trader.sv @@
// Moving-average crossover trader.
// Input channel s_axis: one word per day, tdata = closing price (Q16.16).
// Output channel m_axis: one result word per input word.
// Configuration channel cfg: index 0 short period, 1 long period,
// 2 maximum quantity, 3 maximum money; write only while idle.
// Each price is written into a history RAM, then one read-and-accumulate
// pass over the stored prices (one entry per cycle, registered read) forms
// both sums and both rank counts together. Serial divides follow: the two
// averages when enough prices are stored, then the trade size when a
// crossover calls for a trade. A trading item is offered on m_axis after
// the write, the scan, the divides and the budget check; the next input
// word is accepted only once that result has been taken. The scan walks
// all stored prices through the single read port of the history RAM.
// One item is in work at a time; s_axis_tready is low while it is.
// The result sits in an output register; while the receiver stalls no new
// word is accepted, and nothing is lost.
// Reset clears fill count, pointer, position and registers to defaults; the
// history RAM keeps its contents, and only written entries are ever read.
module moving_average_crossover_trader
  import mact_pkg::*;
#(
  parameter int HISTORY_DEPTH = 1024,
  parameter int MAX_PERIOD    = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] price
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] action, [25:2] trade_quantity, [57:26] short_average,
  // [89:58] long_average, [90] enough_data, [91] budget_blocked
  output logic [95:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int CW   = $clog2(HISTORY_DEPTH + 1);
  localparam int RW   = CW + 1;
  localparam int LIMV = (MAX_PERIOD < HISTORY_DEPTH) ? MAX_PERIOD : HISTORY_DEPTH;
  localparam int PW   = $clog2(LIMV + 1);
  // A window sum holds at most LIMV prices of 32 bits.
  localparam int SW   = 31 + PW;
  localparam int LW   = SW + PW;
  localparam logic [CW-1:0] DEPTH_C   = CW'(HISTORY_DEPTH);
  localparam logic [RW-1:0] DEPTH_R   = RW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
  localparam logic [PW-1:0] LIM_C     = PW'(LIMV);

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_SCAN, S_DEC, S_DIVS, S_DIVL, S_QTY, S_DIVQ, S_BUDGET,
    S_OUT
  } state_t;

  state_t state;

  logic [8:0]  short_period, long_period;
  logic [15:0] max_quantity;
  logic [31:0] max_money;

  logic [AW-1:0] write_pointer;
  logic [CW-1:0] fill_count;
  logic          position_held;

  logic [31:0]   price;
  logic [PW-1:0] sp, lp;
  logic [CW-1:0] idx;
  logic          rd_valid;
  logic [CW-1:0] rd_idx;
  logic [SW-1:0] short_sum, long_sum;
  logic [CW-1:0] cnt_le, cnt_ge;
  logic [LW-1:0] lhs, rhs;
  logic          buying;
  logic [23:0]   qty;
  logic [55:0]   budget_prod;
  result_t       res;

  logic [RW-1:0] back, wp_ext;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  logic          div_start, div_done;
  logic [63:0]   div_num, div_q;
  logic [31:0]   div_den;

  function automatic logic [PW-1:0] eff(input logic [8:0] p);
    logic [PW-1:0] r;
    if (p == 9'd0) r = PW'(1);
    else if ({23'd0, p} > 32'(LIMV)) r = LIM_C;
    else r = PW'(p);
    return r;
  endfunction

  // The ring wraps at the history depth, which need not be a power of two.
  assign back   = RW'(idx) + RW'(1);
  assign wp_ext = RW'(write_pointer);
  assign raddr  = AW'(((wp_ext < back) ? wp_ext + DEPTH_R : wp_ext) - back);

  mact_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (state == S_WRITE),
    .waddr (write_pointer),
    .wdata (price),
    .raddr (raddr),
    .rdata (rdata)
  );

  mact_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = {4'd0, res.budget_blocked, res.enough_data, res.long_average,
                          res.short_average, res.trade_quantity, res.action};
  assign budget_prod   = 56'(qty) * 56'(price);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      short_period  <= SHORT_RESET;
      long_period   <= LONG_RESET;
      max_quantity  <= QTY_RESET;
      max_money     <= MONEY_RESET;
      write_pointer <= '0;
      fill_count    <= '0;
      position_held <= 1'b0;
      div_start     <= 1'b0;
      rd_valid      <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_SHORT: short_period <= cfg_data[8:0];
          REG_LONG:  long_period  <= cfg_data[8:0];
          REG_QTY:   max_quantity <= cfg_data[15:0];
          REG_MONEY: max_money    <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            price <= s_axis_tdata;
            sp    <= eff(short_period);
            lp    <= eff(long_period);
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          write_pointer <= (write_pointer == LAST_SLOT) ? '0 : write_pointer + AW'(1);
          if (fill_count < DEPTH_C) fill_count <= fill_count + CW'(1);
          idx       <= '0;
          rd_valid  <= 1'b0;
          short_sum <= '0;
          long_sum  <= '0;
          cnt_le    <= '0;
          cnt_ge    <= '0;
          res       <= '0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          // Address is issued while the previous read's data is accumulated.
          rd_valid <= (idx < fill_count);
          rd_idx   <= idx;
          idx      <= idx + CW'(1);
          if (rd_valid) begin
            if (rd_idx < CW'(sp)) short_sum <= short_sum + SW'(rdata);
            if (rd_idx < CW'(lp)) long_sum  <= long_sum + SW'(rdata);
            if (price >= rdata) cnt_le <= cnt_le + CW'(1);
            if (price <= rdata) cnt_ge <= cnt_ge + CW'(1);
          end else if (idx != '0) begin
            state <= S_DEC;
          end
          lhs <= '0;
        end
        S_DEC: begin
          lhs   <= LW'(short_sum) * LW'(lp);
          rhs   <= LW'(long_sum) * LW'(sp);
          if (fill_count >= CW'(sp) && fill_count >= CW'(lp)) begin
            res.enough_data <= 1'b1;
            div_num   <= 64'(short_sum);
            div_den   <= 32'(sp);
            div_start <= 1'b1;
            state     <= S_DIVS;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIVS: begin
          if (div_done) begin
            res.short_average <= div_q[31:0];
            div_num   <= 64'(long_sum);
            div_den   <= 32'(lp);
            div_start <= 1'b1;
            state     <= S_DIVL;
          end
        end
        S_DIVL: begin
          if (div_done) begin
            res.long_average <= div_q[31:0];
            state <= S_QTY;
          end
        end
        S_QTY: begin
          if (lhs > rhs && !position_held) begin
            buying    <= 1'b1;
            div_num   <= 64'({max_quantity, 8'd0}) * 64'(cnt_le);
            div_den   <= 32'(fill_count);
            div_start <= 1'b1;
            state     <= S_DIVQ;
          end else if (lhs < rhs && position_held) begin
            buying    <= 1'b0;
            div_num   <= 64'({max_quantity, 8'd0}) * 64'(cnt_ge);
            div_den   <= 32'(fill_count);
            div_start <= 1'b1;
            state     <= S_DIVQ;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIVQ: begin
          if (div_done) begin
            qty   <= div_q[23:0];
            state <= S_BUDGET;
          end
        end
        S_BUDGET: begin
          if (!buying) begin
            res.action         <= ACT_SELL;
            res.trade_quantity <= qty;
            position_held      <= 1'b0;
          end else if (budget_prod <= {max_money, 24'd0}) begin
            res.action         <= ACT_BUY;
            res.trade_quantity <= qty;
            position_held      <= 1'b1;
          end else begin
            res.budget_blocked <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/mact_ram.sv @@
module mact_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/mact_div.sv @@
// Restoring divider, one quotient bit per cycle.
module mact_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] num;
  logic [32:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], num[63]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num  <= dividend;
        rem  <= '0;
        cnt  <= 7'd0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          num <= {num[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], num[63]};
          num <= {num[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = num;

endmodule
